[design/hdw_pkg.sv]
// shared constants and types for the huffman tree walk decoder
package hdw_pkg;

   localparam int NODE_COUNT  = 512;
   localparam int ADDR_W      = $clog2(NODE_COUNT);
   localparam int WORD_BITS   = 8;
   localparam int POS_W       = $clog2(WORD_BITS);
   localparam int SYM_W       = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic             REQ_LOAD   = 1'b0;
   localparam logic             REQ_DECODE = 1'b1;
   localparam logic [SYM_W-1:0] SYM_TERM   = '0;

   typedef struct packed {
      logic [ADDR_W-1:0] left;
      logic [ADDR_W-1:0] right;
      logic              leaf;
      logic [SYM_W-1:0]  sym;
   } hdw_node_type;

   typedef struct packed {
      logic                 is_load;
      logic [ADDR_W-1:0]    addr;
      hdw_node_type         node;
      logic [WORD_BITS-1:0] word;
      logic [POS_W-1:0]     first;
      logic [POS_W-1:0]     last;
   } hdw_cmd_type;

endpackage

[design/hdw_if.sv]
// channel interfaces: request, response and register write
interface hdw_req_if import hdw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [ADDR_W-1:0]    node_addr;
   logic [ADDR_W-1:0]    node_left;
   logic [ADDR_W-1:0]    node_right;
   logic                 node_is_leaf;
   logic [SYM_W-1:0]     node_symbol;
   logic [WORD_BITS-1:0] data_word;
   logic [POS_W-1:0]     first_bit;
   logic [POS_W-1:0]     last_bit;

   modport source (
      output valid, req_type, node_addr, node_left, node_right, node_is_leaf,
             node_symbol, data_word, first_bit, last_bit,
      input  ready
   );
   modport sink (
      input  valid, req_type, node_addr, node_left, node_right, node_is_leaf,
             node_symbol, data_word, first_bit, last_bit,
      output ready
   );
endinterface

interface hdw_rsp_if import hdw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_message;
   logic             last_of_run;

   modport source (output valid, symbol, end_of_message, last_of_run, input ready);
   modport sink (input valid, symbol, end_of_message, last_of_run, output ready);
endinterface

interface hdw_csr_if import hdw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[design/huffman_tree_walk_decoder_core.sv]
// huffman tree walk decoder top level: front end, command queue, tree walker
// a load item writes the node table from ST_IDLE; a decode item is dispatched, walked bit
// by bit in ST_WALK, and then passes through ST_FLUSH when it has results
// the node table has a single read port: each bit's read waits on the last
// the first item after reset or a root write waits while ST_ROOT fetches the root node
// synchronous reset clears control state, root is 0; the node table is not cleared
module huffman_tree_walk_decoder_core import hdw_pkg::*; (
   input logic        clock,
   input logic        reset,
   hdw_req_if.sink    req_ch,
   hdw_rsp_if.source  rsp_ch,
   hdw_csr_if.sink    csr_ch
);

   logic        q_push, q_full, q_pop, q_empty;
   hdw_cmd_type q_push_cmd, q_pop_cmd;

   hdw_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_push_cmd)
   );

   hdw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   hdw_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .q_empty (q_empty),
      .q_cmd   (q_pop_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[design/hdw_front.sv]
// request front end: accepts items, drops empty ones, forms queue commands
module hdw_front import hdw_pkg::*; (
   hdw_req_if.sink     req_ch,
   input  logic        q_full,
   output logic        q_push,
   output hdw_cmd_type q_cmd
);

   logic keep;

   always_comb begin
      if (req_ch.req_type == REQ_LOAD) begin
         keep = ({1'b0, req_ch.node_addr} < (ADDR_W+1)'(NODE_COUNT));
      end else begin
         keep = (req_ch.last_bit >= req_ch.first_bit);
      end
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full && keep;

   assign q_cmd.is_load   = (req_ch.req_type == REQ_LOAD);
   assign q_cmd.addr      = req_ch.node_addr;
   assign q_cmd.node.left  = req_ch.node_left;
   assign q_cmd.node.right = req_ch.node_right;
   assign q_cmd.node.leaf  = req_ch.node_is_leaf;
   assign q_cmd.node.sym   = req_ch.node_symbol;
   assign q_cmd.word      = req_ch.data_word;
   assign q_cmd.first     = req_ch.first_bit;
   assign q_cmd.last      = req_ch.last_bit;

endmodule

[design/hdw_queue.sv]
// short command queue between front end and tree walker
module hdw_queue import hdw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hdw_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output hdw_cmd_type pop_cmd,
   output logic        empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hdw_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/hdw_walk.sv]
// tree walker: node table, bit-serial walk, result holding and output register
module hdw_walk import hdw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hdw_csr_if.sink     csr_ch,
   input  logic        q_empty,
   input  hdw_cmd_type q_cmd,
   output logic        q_pop,
   hdw_rsp_if.source   rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROOT  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   hdw_node_type tbl_mem [NODE_COUNT];
   hdw_node_type rd_data_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr;

   logic [1:0]           st_ff, st_in;
   logic [ADDR_W-1:0]    root_ff, root_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;
   hdw_node_type         rootn_ff, rootn_in;
   logic                 rootv_ff, rootv_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [POS_W:0]       pos_ff, pos_in;
   logic [POS_W-1:0]     lastpos_ff, lastpos_in;
   logic                 chk_ff, chk_in;
   logic                 pend_v_ff, pend_v_in;
   logic [SYM_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                 pend_eom_ff, pend_eom_in;
   logic                 out_v_ff, out_v_in;
   logic [SYM_W-1:0]     out_sym_ff, out_sym_in;
   logic                 out_eom_ff, out_eom_in;
   logic                 out_last_ff, out_last_in;

   logic              out_free, leaf, eom, more, bit_val;
   hdw_node_type      eff;
   logic [ADDR_W-1:0] child;

   // node table with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[q_cmd.addr] <= q_cmd.node;
      end
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign leaf     = chk_ff && rd_data_ff.leaf;
   assign eom      = leaf && (rd_data_ff.sym == SYM_TERM);
   assign more     = (pos_ff <= {1'b0, lastpos_ff});
   assign eff      = leaf ? rootn_ff : rd_data_ff;
   assign bit_val  = word_ff[pos_ff[POS_W-1:0]];
   assign child    = bit_val ? eff.right : eff.left;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      st_in       = st_ff;
      root_in     = root_ff;
      cur_in      = cur_ff;
      rootn_in    = rootn_ff;
      rootv_in    = rootv_ff;
      word_in     = word_ff;
      pos_in      = pos_ff;
      lastpos_in  = lastpos_ff;
      chk_in      = chk_ff;
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      pend_eom_in = pend_eom_ff;
      out_v_in    = out_v_ff && !rsp_ch.ready;
      out_sym_in  = out_sym_ff;
      out_eom_in  = out_eom_ff;
      out_last_in = out_last_ff;
      rd_en       = 1'b0;
      rd_addr     = cur_ff;
      wr_en       = 1'b0;
      q_pop       = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (!rootv_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = root_ff;
                  st_in   = ST_ROOT;
               end else begin
                  q_pop = 1'b1;
                  if (q_cmd.is_load) begin
                     wr_en = 1'b1;
                     if (q_cmd.addr == root_ff) begin
                        rootn_in = q_cmd.node;
                     end
                  end else begin
                     rd_en      = 1'b1;
                     rd_addr    = cur_ff;
                     word_in    = q_cmd.word;
                     pos_in     = {1'b0, q_cmd.first};
                     lastpos_in = q_cmd.last;
                     chk_in     = 1'b0;
                     st_in      = ST_WALK;
                  end
               end
            end
         end
         ST_ROOT: begin
            rootn_in = rd_data_ff;
            rootv_in = 1'b1;
            st_in    = ST_IDLE;
         end
         ST_WALK: begin
            if (!(leaf && pend_v_ff && !out_free)) begin
               if (leaf) begin
                  if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_sym_in  = pend_sym_ff;
                     out_eom_in  = pend_eom_ff;
                     out_last_in = 1'b0;
                  end
                  pend_v_in   = 1'b1;
                  pend_sym_in = rd_data_ff.sym;
                  pend_eom_in = eom;
                  cur_in      = root_ff;
               end
               chk_in = 1'b0;
               if (!eom && more) begin
                  rd_en   = 1'b1;
                  rd_addr = child;
                  cur_in  = child;
                  pos_in  = pos_ff + 1'b1;
                  chk_in  = 1'b1;
               end else begin
                  st_in = (leaf || pend_v_ff) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_sym_in  = pend_sym_ff;
               out_eom_in  = pend_eom_ff;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
               st_in       = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // root rewrite also restarts the next item's walk at the new root
      if (csr_ch.valid) begin
         root_in  = csr_ch.data;
         cur_in   = csr_ch.data;
         rootv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         root_ff   <= '0;
         cur_ff    <= '0;
         rootv_ff  <= 1'b0;
         chk_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         st_ff     <= st_in;
         root_ff   <= root_in;
         cur_ff    <= cur_in;
         rootv_ff  <= rootv_in;
         chk_ff    <= chk_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rootn_ff    <= rootn_in;
      word_ff     <= word_in;
      pos_ff      <= pos_in;
      lastpos_ff  <= lastpos_in;
      pend_sym_ff <= pend_sym_in;
      pend_eom_ff <= pend_eom_in;
      out_sym_ff  <= out_sym_in;
      out_eom_ff  <= out_eom_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid          = out_v_ff;
   assign rsp_ch.symbol         = out_sym_ff;
   assign rsp_ch.end_of_message = out_eom_ff;
   assign rsp_ch.last_of_run    = out_last_ff;

endmodule
